### hdl/fibt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt_pkg
// Shared widths, register indexes, configuration bundle and helper functions
// for the four-index block transpose address generator.
// ----------------------------------------------------------------------------
package fibt_pkg;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 28;
  localparam int X_CFG_W    = 6;
  localparam int G_CFG_W    = 5;
  localparam int B_CFG_W    = 11;
  localparam int CX_W       = X_CFG_W + G_CFG_W;
  localparam int BS_W       = 2 * CX_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam int DEF_MAX_INNER  = 32;
  localparam int DEF_MAX_GROUP  = 16;
  localparam int DEF_MAX_BLOCKS = 1024;

  localparam logic [REG_IDX_W-1:0] REG_INNER_WIDTH_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_WIDTH_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_COUNT_A = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_COUNT_B = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_TOTAL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SWAP_MODE     = 3'd5;

  // Effective (clamped) extents and derived products
  typedef struct packed {
    logic [X_CFG_W-1:0] x3n;
    logic [X_CFG_W-1:0] x2n;
    logic [G_CFG_W-1:0] c3n;
    logic [G_CFG_W-1:0] c2n;
    logic [B_CFG_W-1:0] nb;
    logic               swap;
    logic [CX_W-1:0]    cx2;
    logic [CX_W-1:0]    cx3;
    logic [BS_W-1:0]    blk_size;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic last;
  } blk_ctl_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // grp * extent + pos
  function automatic int term_w(input int n_group);
    return idx_w(n_group) + X_CFG_W + 1;
  endfunction

  // zero reads as one, above the maximum reads as the maximum
  function automatic logic [B_CFG_W-1:0] clamp_ext(input logic [B_CFG_W-1:0] v,
                                                    input int hi);
    logic [B_CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = B_CFG_W'(1);
    end else if (int'(v) > hi) begin
      r = B_CFG_W'(hi);
    end
    return r;
  endfunction

endpackage

### hdl/fibt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt stream interfaces
// Valid/ready channels for source words in and placed words out.
// ----------------------------------------------------------------------------
interface fibt_in_if;
  import fibt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_in;
  modport source (output valid, output data_in, input ready);
  modport sink (input valid, input data_in, output ready);
endinterface

interface fibt_out_if;
  import fibt_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [ADDR_W-1:0] target_address;
  logic              last_word;
  modport source (output valid, output data_out, output target_address,
                  output last_word, input ready);
  modport sink (input valid, input data_out, input target_address,
                input last_word, output ready);
endinterface

### hdl/fibt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt_cfg_regs
// APB register file: raw extents, clamped view and the products that the
// address datapath needs, updated on the write itself where possible.
// ----------------------------------------------------------------------------
module fibt_cfg_regs #(
  parameter int MAX_INNER  = fibt_pkg::DEF_MAX_INNER,
  parameter int MAX_GROUP  = fibt_pkg::DEF_MAX_GROUP,
  parameter int MAX_BLOCKS = fibt_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fibt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fibt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fibt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output fibt_pkg::cfg_t                  cfg
);
  import fibt_pkg::*;

  logic [X_CFG_W-1:0]   x3_raw;
  logic [X_CFG_W-1:0]   x2_raw;
  logic [G_CFG_W-1:0]   c3_raw;
  logic [G_CFG_W-1:0]   c2_raw;
  logic [B_CFG_W-1:0]   nb_raw;
  logic                 swap;
  logic [CX_W-1:0]      cx2;
  logic [CX_W-1:0]      cx3;
  logic [BS_W-1:0]      blk_size;
  logic [X_CFG_W-1:0]   x3n;
  logic [X_CFG_W-1:0]   x2n;
  logic [G_CFG_W-1:0]   c3n;
  logic [G_CFG_W-1:0]   c2n;
  logic [X_CFG_W-1:0]   wr_xn;
  logic [G_CFG_W-1:0]   wr_cn;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  assign x3n = X_CFG_W'(clamp_ext(B_CFG_W'(x3_raw), MAX_INNER));
  assign x2n = X_CFG_W'(clamp_ext(B_CFG_W'(x2_raw), MAX_INNER));
  assign c3n = G_CFG_W'(clamp_ext(B_CFG_W'(c3_raw), MAX_GROUP));
  assign c2n = G_CFG_W'(clamp_ext(B_CFG_W'(c2_raw), MAX_GROUP));

  assign wr_xn = X_CFG_W'(clamp_ext(B_CFG_W'(pwdata[X_CFG_W-1:0]), MAX_INNER));
  assign wr_cn = G_CFG_W'(clamp_ext(B_CFG_W'(pwdata[G_CFG_W-1:0]), MAX_GROUP));

  always_ff @(posedge clk) begin
    if (rst) begin
      x3_raw   <= X_CFG_W'(1);
      x2_raw   <= X_CFG_W'(1);
      c3_raw   <= G_CFG_W'(1);
      c2_raw   <= G_CFG_W'(1);
      nb_raw   <= B_CFG_W'(1);
      swap     <= 1'b0;
      cx2      <= CX_W'(1);
      cx3      <= CX_W'(1);
      blk_size <= BS_W'(1);
    end else begin
      blk_size <= BS_W'(cx2) * BS_W'(cx3);
      if (wr_en) begin
        case (reg_idx)
          REG_INNER_WIDTH_A: begin
            x3_raw <= pwdata[X_CFG_W-1:0];
            cx3    <= CX_W'(wr_xn) * CX_W'(c3n);
          end
          REG_INNER_WIDTH_B: begin
            x2_raw <= pwdata[X_CFG_W-1:0];
            cx2    <= CX_W'(wr_xn) * CX_W'(c2n);
          end
          REG_GROUP_COUNT_A: begin
            c3_raw <= pwdata[G_CFG_W-1:0];
            cx3    <= CX_W'(x3n) * CX_W'(wr_cn);
          end
          REG_GROUP_COUNT_B: begin
            c2_raw <= pwdata[G_CFG_W-1:0];
            cx2    <= CX_W'(x2n) * CX_W'(wr_cn);
          end
          REG_BLOCK_TOTAL: begin
            nb_raw <= pwdata[B_CFG_W-1:0];
          end
          REG_SWAP_MODE: begin
            swap <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INNER_WIDTH_A: prdata = APB_DATA_W'(x3_raw);
      REG_INNER_WIDTH_B: prdata = APB_DATA_W'(x2_raw);
      REG_GROUP_COUNT_A: prdata = APB_DATA_W'(c3_raw);
      REG_GROUP_COUNT_B: prdata = APB_DATA_W'(c2_raw);
      REG_BLOCK_TOTAL:   prdata = APB_DATA_W'(nb_raw);
      REG_SWAP_MODE:     prdata = APB_DATA_W'(swap);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.x3n      = x3n;
    cfg.x2n      = x2n;
    cfg.c3n      = c3n;
    cfg.c2n      = c2n;
    cfg.nb       = B_CFG_W'(clamp_ext(nb_raw, MAX_BLOCKS));
    cfg.swap     = swap;
    cfg.cx2      = cx2;
    cfg.cx3      = cx3;
    cfg.blk_size = blk_size;
  end

endmodule

### hdl/fibt_index_ctr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt_index_ctr
// Nested source index counters and the input register. Each accepted word
// is latched with its row terms grp_a*X3+pos_a and grp_b*X2+pos_b.
// ----------------------------------------------------------------------------
module fibt_index_ctr #(
  parameter int MAX_INNER  = fibt_pkg::DEF_MAX_INNER,
  parameter int MAX_GROUP  = fibt_pkg::DEF_MAX_GROUP,
  parameter int MAX_BLOCKS = fibt_pkg::DEF_MAX_BLOCKS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  fibt_pkg::cfg_t                               cfg,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [fibt_pkg::DATA_W-1:0]                  data_in,
  output logic                                         s1_valid,
  input  logic                                         s1_ready,
  output logic [fibt_pkg::DATA_W-1:0]                  s1_data,
  output logic [fibt_pkg::term_w(MAX_GROUP)-1:0]       s1_t_a,
  output logic [fibt_pkg::term_w(MAX_GROUP)-1:0]       s1_t_b,
  output fibt_pkg::blk_ctl_t                           s1_ctl
);
  import fibt_pkg::*;

  localparam int XI_W = idx_w(MAX_INNER);
  localparam int GI_W = idx_w(MAX_GROUP);
  localparam int BI_W = idx_w(MAX_BLOCKS);
  localparam int T_W  = term_w(MAX_GROUP);

  logic [XI_W-1:0] pos_a, pos_a_next;
  logic [XI_W-1:0] pos_b, pos_b_next;
  logic [GI_W-1:0] grp_a, grp_a_next;
  logic [GI_W-1:0] grp_b, grp_b_next;
  logic [BI_W-1:0] block_index, block_index_next;
  logic            wrap_a, wrap_b, wrap_ga, wrap_gb, wrap_blk;
  logic            accept;
  logic [T_W-1:0]  t_a, t_b;
  blk_ctl_t        ctl;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // counters may sit beyond a shrunk extent; >= makes them wrap
  assign wrap_a   = (XI_W+1)'(pos_a) + (XI_W+1)'(1) >= (XI_W+1)'(cfg.x3n);
  assign wrap_b   = (XI_W+1)'(pos_b) + (XI_W+1)'(1) >= (XI_W+1)'(cfg.x2n);
  assign wrap_ga  = (GI_W+1)'(grp_a) + (GI_W+1)'(1) >= (GI_W+1)'(cfg.c3n);
  assign wrap_gb  = (GI_W+1)'(grp_b) + (GI_W+1)'(1) >= (GI_W+1)'(cfg.c2n);
  assign wrap_blk = (BI_W+1)'(block_index) + (BI_W+1)'(1) >= (BI_W+1)'(cfg.nb);

  assign t_a = T_W'(grp_a) * T_W'(cfg.x3n) + T_W'(pos_a);
  assign t_b = T_W'(grp_b) * T_W'(cfg.x2n) + T_W'(pos_b);

  assign ctl.last = wrap_a && wrap_b && wrap_ga && wrap_gb && wrap_blk;
  assign ctl.adv  = wrap_a && wrap_b && wrap_ga && wrap_gb && !wrap_blk;

  always_comb begin
    pos_a_next       = pos_a + XI_W'(1);
    pos_b_next       = pos_b;
    grp_a_next       = grp_a;
    grp_b_next       = grp_b;
    block_index_next = block_index;
    if (wrap_a) begin
      pos_a_next = '0;
      pos_b_next = pos_b + XI_W'(1);
      if (wrap_b) begin
        pos_b_next = '0;
        grp_a_next = grp_a + GI_W'(1);
        if (wrap_ga) begin
          grp_a_next = '0;
          grp_b_next = grp_b + GI_W'(1);
          if (wrap_gb) begin
            grp_b_next       = '0;
            block_index_next = wrap_blk ? '0 : block_index + BI_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a       <= '0;
      pos_b       <= '0;
      grp_a       <= '0;
      grp_b       <= '0;
      block_index <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        pos_a       <= pos_a_next;
        pos_b       <= pos_b_next;
        grp_a       <= grp_a_next;
        grp_b       <= grp_b_next;
        block_index <= block_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= data_in;
      s1_t_a  <= t_a;
      s1_t_b  <= t_b;
      s1_ctl  <= ctl;
    end
  end

endmodule

### hdl/fibt_addr_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt_addr_out
// Target address datapath and result register. Holds the running block base,
// advanced by blk_size as each block's last word loads the result register.
// ----------------------------------------------------------------------------
module fibt_addr_out #(
  parameter int MAX_GROUP = fibt_pkg::DEF_MAX_GROUP
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fibt_pkg::cfg_t                         cfg,
  input  logic                                   s1_valid,
  output logic                                   s1_ready,
  input  logic [fibt_pkg::DATA_W-1:0]            s1_data,
  input  logic [fibt_pkg::term_w(MAX_GROUP)-1:0] s1_t_a,
  input  logic [fibt_pkg::term_w(MAX_GROUP)-1:0] s1_t_b,
  input  fibt_pkg::blk_ctl_t                     s1_ctl,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [fibt_pkg::DATA_W-1:0]            data_out,
  output logic [fibt_pkg::ADDR_W-1:0]            target_address,
  output logic                                   last_word
);
  import fibt_pkg::*;

  localparam int T_W = term_w(MAX_GROUP);

  logic              out_free;
  logic              load;
  logic [ADDR_W-1:0] block_base, block_base_next;
  logic [T_W-1:0]    t_outer, t_inner;
  logic [CX_W-1:0]   stride;
  logic [ADDR_W-1:0] addr;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = out_free;
  assign load     = s1_valid && out_free;

  assign t_outer = cfg.swap ? s1_t_b : s1_t_a;
  assign t_inner = cfg.swap ? s1_t_a : s1_t_b;
  assign stride  = cfg.swap ? cfg.cx3 : cfg.cx2;
  assign addr    = block_base + ADDR_W'(t_outer) * ADDR_W'(stride) + ADDR_W'(t_inner);

  always_comb begin
    block_base_next = block_base;
    if (s1_ctl.last) begin
      block_base_next = '0;
    end else if (s1_ctl.adv) begin
      block_base_next = block_base + ADDR_W'(cfg.blk_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      block_base <= '0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (load) begin
        block_base <= block_base_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_out       <= s1_data;
      target_address <= addr;
      last_word      <= s1_ctl.last;
    end
  end

endmodule

### hdl/four_index_block_transpose_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_index_block_transpose_core
// Streams 64-bit words in source order and tags each with its element index
// in the transposed target array.
// ----------------------------------------------------------------------------
//  channel     dir  handshake               payload
//  in_stream   in   valid/ready             data_in
//  out_stream  out  valid/ready             data_out, target_address, last_word
//  apb         in   psel/penable, pready=1  paddr, pwdata, pwrite / prdata
//
//  One word per cycle sustained while out_stream.ready stays high; a word is
//  on out_stream once it has passed the input register, then the result
//  register with the address multiply-add and the block base accumulator.
//  Reset: counters and block base to zero, extents to 1, swap_mode to 0.
//  out_stream.ready low holds the result; the input register takes one more
//  word, then in_stream.ready drops until the result moves.
// ----------------------------------------------------------------------------
module four_index_block_transpose_core #(
  parameter int MAX_INNER  = fibt_pkg::DEF_MAX_INNER,
  parameter int MAX_GROUP  = fibt_pkg::DEF_MAX_GROUP,
  parameter int MAX_BLOCKS = fibt_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  fibt_in_if.sink                         in_stream,
  fibt_out_if.source                      out_stream,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fibt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fibt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fibt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fibt_pkg::*;

  localparam int T_W = term_w(MAX_GROUP);

  cfg_t              cfg;
  logic              s1_valid;
  logic              s1_ready;
  logic [DATA_W-1:0] s1_data;
  logic [T_W-1:0]    s1_t_a;
  logic [T_W-1:0]    s1_t_b;
  blk_ctl_t          s1_ctl;

  fibt_cfg_regs #(
    .MAX_INNER (MAX_INNER),
    .MAX_GROUP (MAX_GROUP),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  fibt_index_ctr #(
    .MAX_INNER (MAX_INNER),
    .MAX_GROUP (MAX_GROUP),
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctr (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_stream.valid),
    .in_ready(in_stream.ready),
    .data_in (in_stream.data_in),
    .s1_valid(s1_valid),
    .s1_ready(s1_ready),
    .s1_data (s1_data),
    .s1_t_a  (s1_t_a),
    .s1_t_b  (s1_t_b),
    .s1_ctl  (s1_ctl)
  );

  fibt_addr_out #(
    .MAX_GROUP(MAX_GROUP)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1_data       (s1_data),
    .s1_t_a        (s1_t_a),
    .s1_t_b        (s1_t_b),
    .s1_ctl        (s1_ctl),
    .out_valid     (out_stream.valid),
    .out_ready     (out_stream.ready),
    .data_out      (out_stream.data_out),
    .target_address(out_stream.target_address),
    .last_word     (out_stream.last_word)
  );

endmodule

### hdl/fibt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibt_checker
// Port-level checks on the transpose core: stall hold, reset, pass-through
// into the result register and input readiness under an open output.
// ----------------------------------------------------------------------------
module fibt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [fibt_pkg::DATA_W-1:0]     data_in,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fibt_pkg::DATA_W-1:0]     data_out,
  input logic [fibt_pkg::ADDR_W-1:0]     target_address,
  input logic                            last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out)
      && $stable(target_address) && $stable(last_word))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid && data_out == $past(data_in, 2))
    else $error("word not delivered two cycles after transfer");

  a_no_bubble: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input stalled while output open");

endmodule

bind four_index_block_transpose_core fibt_checker u_fibt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_stream.valid),
  .in_ready      (in_stream.ready),
  .data_in       (in_stream.data_in),
  .out_valid     (out_stream.valid),
  .out_ready     (out_stream.ready),
  .data_out      (out_stream.data_out),
  .target_address(out_stream.target_address),
  .last_word     (out_stream.last_word)
);

### sim/four_index_block_transpose_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_index_block_transpose_core_test
// Drives source words into the transpose core under a range of layouts and
// compares every placed word (data, target address, last flag) with a
// behavioral model of the address counters. Both stream sides stall at
// random, the output is held off long enough to back up the input, and the
// registers are reprogrammed between phases, including mid-transfer.
// ----------------------------------------------------------------------------
module four_index_block_transpose_core_test;
  import fibt_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } placed_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fibt_in_if  in_ch ();
  fibt_out_if out_ch ();

  four_index_block_transpose_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // layout registers as programmed
  logic [X_CFG_W-1:0] width_a, width_b;
  logic [G_CFG_W-1:0] groups_a, groups_b;
  logic [B_CFG_W-1:0] blocks_total;
  logic               swapped;

  // source position counters
  logic [4:0]        pos_a, pos_b;
  logic [3:0]        grp_a, grp_b;
  logic [9:0]        block_num;
  logic [ADDR_W-1:0] block_base;

  placed_word_t placed_words[$];

  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int last_flags = 0;
  int reg_writes = 0;
  bit idle_on = 1'b0;
  int hold_request = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned eff_extent(input longint unsigned v,
                                                 input longint unsigned hi);
    if (v == 0) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic void place_word(input logic [DATA_W-1:0] w);
    longint unsigned x3n, x2n, c3n, c2n, nb, addr;
    bit wa, wb, wga, wgb, wblk;
    placed_word_t pw;
    x3n = eff_extent(width_a, DEF_MAX_INNER);
    x2n = eff_extent(width_b, DEF_MAX_INNER);
    c3n = eff_extent(groups_a, DEF_MAX_GROUP);
    c2n = eff_extent(groups_b, DEF_MAX_GROUP);
    nb  = eff_extent(blocks_total, DEF_MAX_BLOCKS);
    if (swapped) begin
      addr = block_base + (grp_b * x2n + pos_b) * (c3n * x3n) + grp_a * x3n + pos_a;
    end else begin
      addr = block_base + (grp_a * x3n + pos_a) * (c2n * x2n) + grp_b * x2n + pos_b;
    end
    wa   = (pos_a + 64'd1) >= x3n;
    wb   = (pos_b + 64'd1) >= x2n;
    wga  = (grp_a + 64'd1) >= c3n;
    wgb  = (grp_b + 64'd1) >= c2n;
    wblk = (block_num + 64'd1) >= nb;
    pw.data = w;
    pw.addr = ADDR_W'(addr);
    pw.last = wa && wb && wga && wgb && wblk;
    placed_words.push_back(pw);
    pos_a = wa ? 5'd0 : pos_a + 5'd1;
    if (wa) begin
      pos_b = wb ? 5'd0 : pos_b + 5'd1;
    end
    if (wa && wb) begin
      grp_a = wga ? 4'd0 : grp_a + 4'd1;
    end
    if (wa && wb && wga) begin
      grp_b = wgb ? 4'd0 : grp_b + 4'd1;
    end
    if (wa && wb && wga && wgb) begin
      if (wblk) begin
        block_num  = '0;
        block_base = '0;
      end else begin
        block_num  = block_num + 10'd1;
        block_base = ADDR_W'(block_base + x3n * x2n * c3n * c2n);
      end
    end
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_INNER_WIDTH_A: width_a      = val[X_CFG_W-1:0];
      REG_INNER_WIDTH_B: width_b      = val[X_CFG_W-1:0];
      REG_GROUP_COUNT_A: groups_a     = val[G_CFG_W-1:0];
      REG_GROUP_COUNT_B: groups_b     = val[G_CFG_W-1:0];
      REG_BLOCK_TOTAL:   blocks_total = val[B_CFG_W-1:0];
      REG_SWAP_MODE:     swapped      = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_layout(input int unsigned x3, input int unsigned x2,
                            input int unsigned c3, input int unsigned c2,
                            input int unsigned nb, input int unsigned swp);
    write_reg(REG_INNER_WIDTH_A, x3);
    write_reg(REG_INNER_WIDTH_B, x2);
    write_reg(REG_GROUP_COUNT_A, c3);
    write_reg(REG_GROUP_COUNT_B, c2);
    write_reg(REG_BLOCK_TOTAL, nb);
    write_reg(REG_SWAP_MODE, swp);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_word(input logic [DATA_W-1:0] w);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    place_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word({$urandom, $urandom});
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (placed_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_default_extents;
    send_word('0);
    send_word('1);
    send_word({16{4'hA}});
    send_word({16{4'h5}});
    drain();
  endtask

  task automatic test_normal_layout;
    set_layout(2, 1, 2, 2, 1, 0);
    send_random(8);
    drain();
  endtask

  task automatic test_swapped_layout;
    set_layout(1, 2, 2, 1, 2, 1);
    send_random(8);
    drain();
  endtask

  task automatic test_extent_clamping;
    set_layout(0, 0, 0, 0, 0, 0);
    send_random(2);
    drain();
    set_layout(63, 63, 31, 31, 2047, 1);
    send_random(3);
    drain();
  endtask

  task automatic test_shrink_mid_transfer;
    set_layout(4, 2, 1, 1, 4, 0);
    send_random(3);
    drain();
    write_reg(REG_INNER_WIDTH_A, 2);
    send_random(3);
    drain();
  endtask

  task automatic test_random_layouts;
    for (int phase = 0; phase < 14; phase++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        set_layout(32, 32, 16, 16, 1024, $urandom_range(0, 1));
      end else if ($urandom_range(0, 4) == 0) begin
        set_layout($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 2047), $urandom_range(0, 1));
      end else begin
        set_layout($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3),
                   $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 1));
      end
      send_random($urandom_range(30, 60));
      drain();
    end
  endtask

  task automatic test_output_backpressure;
    idle_on = 1'b0;
    set_layout(3, 2, 2, 1, 2, 1);
    hold_request = 150;
    send_random(30);
    // sender waits for the output side to catch up
    drain();
    send_random(30);
    drain();
  endtask

  task automatic test_full_rate;
    idle_on = 1'b0;
    set_layout($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2),
               $urandom_range(1, 2), $urandom_range(1, 3), $urandom_range(0, 1));
    send_random(80);
    drain();
  endtask

  // output side: random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
    end else if (hold_request > 0) begin
      stall_left = hold_request - 1;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    placed_word_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (placed_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, data %h address %h last %b", $time,
                 out_ch.data_out, out_ch.target_address, out_ch.last_word);
      end else begin
        want = placed_words.pop_front();
        words_checked++;
        if (out_ch.last_word === 1'b1) begin
          last_flags++;
        end
        if (out_ch.data_out !== want.data) begin
          error_count++;
          $display("%0t: data_out expected %h actual %h", $time, want.data,
                   out_ch.data_out);
        end
        if (out_ch.target_address !== want.addr) begin
          error_count++;
          $display("%0t: target_address expected %h actual %h", $time, want.addr,
                   out_ch.target_address);
        end
        if (out_ch.last_word !== want.last) begin
          error_count++;
          $display("%0t: last_word expected %b actual %b", $time, want.last,
                   out_ch.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d words outstanding", $time,
               STALL_LIMIT, placed_words.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.data_in = '0;
    out_ch.ready  = 1'b1;
    width_a      = X_CFG_W'(1);
    width_b      = X_CFG_W'(1);
    groups_a     = G_CFG_W'(1);
    groups_b     = G_CFG_W'(1);
    blocks_total = B_CFG_W'(1);
    swapped      = 1'b0;
    pos_a = '0;
    pos_b = '0;
    grp_a = '0;
    grp_b = '0;
    block_num  = '0;
    block_base = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_default_extents();
    test_normal_layout();
    test_swapped_layout();
    test_extent_clamping();
    test_shrink_mid_transfer();
    test_random_layouts();
    test_output_backpressure();
    test_full_rate();
    $display("%0d words placed and checked over %0d register writes", words_checked,
             reg_writes);
    $display("%0d transfers closed with last_word; %0d mismatches", last_flags,
             error_count);
    if (error_count == 0 && words_checked == words_sent) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
